// ----- rtl/core/bsas_pkg.sv -----
// Shared types and codes for the bounded shift-array store.
// No dependencies; used by every module in rtl/core.
package bsas_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_APPEND = 3'd2;
  localparam logic [2:0] REQ_INSERT = 3'd3;
  localparam logic [2:0] REQ_REMOVE = 3'd4;
  localparam logic [2:0] REQ_FIND   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         position;
    logic signed [31:0] word_in;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] word_out;
    logic [3:0]         found_at;
    logic [4:0]         fill_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic scan_step;  // compare one entry against the search key
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_scan; // incoming request is a find on a non-empty store
    logic scan_done;  // current scan step hits or reaches the last entry
  } dp_sts_t;

endpackage

// ----- rtl/core/bounded_shift_array_store_top.sv -----
// Top level of the bounded shift-array store: sequencer plus datapath.
// Depends on bsas_pkg, bsas_ctrl and bsas_dpath.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+-------------------------------------
//   request | in_valid  | in_ready  | in_data  (req_type, position, word_in)
//   result  | out_valid | out_ready | out_data (status, word_out, found_at,
//           |           |           |           fill_count)
//
// Results: read, write, append, insert-front, remove and a find on an empty
//   store write the result register at accept; it is valid in the next cycle.
//   A find walks the held entries through the single read port, one compare
//   per cycle, up to the first hit or, on a miss, through every held entry.
// Reset: rst clears the fill count and the sequencer; entry contents are
//   not cleared and no clearing pass is run.
// Stalls: a result waits in the output register while out_ready is low; a
//   new request beat is taken in the same cycle the waiting result leaves.
module bounded_shift_array_store_top #(
  parameter int unsigned CAPACITY = bsas_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bsas_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bsas_pkg::rsp_t   out_data
);

  bsas_pkg::ctrl_cmd_t cmd;
  bsas_pkg::dp_sts_t   sts;

  // sequencer: idle / search walk / result waiting
  bsas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry registers with parallel shift, fill count, result register
  bsas_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .req (in_data),
    .cmd (cmd),
    .sts (sts),
    .rsp (out_data)
  );

endmodule

// ----- rtl/core/bsas_ctrl.sv -----
// Request sequencer for the bounded shift-array store.
// Depends on bsas_pkg (command/status structs).
module bsas_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bsas_pkg::dp_sts_t    sts,
  output bsas_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       beat;

  assign in_ready  = (state == S_IDLE) || ((state == S_DONE) && out_ready);
  assign out_valid = (state == S_DONE);
  assign beat      = in_valid && in_ready;

  assign cmd.accept    = beat;
  assign cmd.scan_step = (state == S_SCAN);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (beat) begin
          state_next = sts.needs_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (beat) begin
          state_next = sts.needs_scan ? S_SCAN : S_DONE;
        end else if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !in_ready)
    else $error("input taken during scan");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before delivery");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && sts.scan_done) |=> out_valid)
    else $error("finished scan did not raise result");

endmodule

// ----- rtl/core/bsas_dpath.sv -----
// Entry store, fill count, search walker and result register.
// Depends on bsas_pkg (payload and command/status structs, codes).
module bsas_dpath #(
  parameter int unsigned CAPACITY = bsas_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bsas_pkg::req_t       req,
  input  bsas_pkg::ctrl_cmd_t  cmd,
  output bsas_pkg::dp_sts_t    sts,
  output bsas_pkg::rsp_t       rsp
);

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned HELD_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = HELD_W + 8;

  logic [31:0]        entries [CAPACITY];
  logic [31:0]        entries_next [CAPACITY];
  logic [HELD_W-1:0]  held;
  logic [HELD_W-1:0]  held_next;
  logic [IDX_W-1:0]   scan_idx;
  logic [31:0]        scan_key;

  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   held_ext;
  logic [IDX_W-1:0]   pos_idx;
  logic               in_range;
  logic               full;
  logic [IDX_W-1:0]   rd_addr;
  logic [31:0]        rd_word;
  logic               hit;
  logic               last;
  logic [IDX_W+3:0]   at_ext;
  logic [HELD_W+4:0]  fill_ext;
  logic [HELD_W+4:0]  held_next_ext;
  logic [1:0]         status_next;
  logic [31:0]        word_next;

  assign pos_ext  = {{HELD_W{1'b0}}, req.position};
  assign held_ext = {8'b0, held};
  assign pos_idx  = pos_ext[IDX_W-1:0];
  assign in_range = pos_ext < held_ext;
  assign full     = (held == HELD_W'(CAPACITY));

  // single read port shared by read requests and the search walk
  assign rd_addr = cmd.scan_step ? scan_idx : pos_idx;
  assign rd_word = entries[rd_addr];

  assign hit  = (rd_word == scan_key);
  assign last = ((HELD_W'(scan_idx) + HELD_W'(1)) == held);

  assign sts.needs_scan = (req.req_type == bsas_pkg::REQ_FIND) && (held != '0);
  assign sts.scan_done  = hit || last;

  assign at_ext   = {4'b0, scan_idx};
  assign fill_ext = {5'b0, held};

  always_comb begin
    held_next   = held;
    status_next = bsas_pkg::ST_OK;
    word_next   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
    end
    unique case (req.req_type)
      bsas_pkg::REQ_READ: begin
        if (in_range) word_next = rd_word;
        else          status_next = bsas_pkg::ST_RANGE;
      end
      bsas_pkg::REQ_WRITE: begin
        if (in_range) entries_next[pos_idx] = req.word_in;
        else          status_next = bsas_pkg::ST_RANGE;
      end
      bsas_pkg::REQ_APPEND: begin
        if (!full) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (HELD_W'(i) == held) entries_next[i] = req.word_in;
          end
          held_next = held + HELD_W'(1);
        end else begin
          status_next = bsas_pkg::ST_FULL;
        end
      end
      bsas_pkg::REQ_INSERT: begin
        if (!full) begin
          entries_next[0] = req.word_in;
          for (int i = 1; i < CAPACITY; i++) begin
            entries_next[i] = entries[i-1];
          end
          held_next = held + HELD_W'(1);
        end else begin
          status_next = bsas_pkg::ST_FULL;
        end
      end
      bsas_pkg::REQ_REMOVE: begin
        if (in_range) begin
          for (int i = 0; i + 1 < CAPACITY; i++) begin
            if (IDX_W'(i) >= pos_idx) entries_next[i] = entries[i+1];
          end
          held_next = held - HELD_W'(1);
        end else begin
          status_next = bsas_pkg::ST_RANGE;
        end
      end
      bsas_pkg::REQ_FIND: begin
        // empty store: immediate miss; otherwise the walk fills the result
        status_next = bsas_pkg::ST_NOTFOUND;
      end
      default: ;
    endcase
  end

  assign held_next_ext = {5'b0, held_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.accept) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_key <= req.word_in;
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !sts.needs_scan) begin
      rsp.status     <= status_next;
      rsp.word_out   <= word_next;
      rsp.found_at   <= '0;
      rsp.fill_count <= held_next_ext[4:0];
    end else if (cmd.scan_step && sts.scan_done) begin
      rsp.status     <= hit ? bsas_pkg::ST_OK : bsas_pkg::ST_NOTFOUND;
      rsp.word_out   <= '0;
      rsp.found_at   <= hit ? at_ext[3:0] : 4'b0;
      rsp.fill_count <= fill_ext[4:0];
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HELD_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (HELD_W'(scan_idx) < held))
    else $error("scan beyond held entries");

  a_scan_keeps_store: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |=> $stable(held))
    else $error("fill count moved during scan");

endmodule
